// ----- sv/rvn_pkg.sv -----
// ----------------------------------------------------------------------------
// rvn_pkg: shared types and constants of the ring vertex normal unit
// Widths of the normalisation datapath, the codes of the shared
// square root / divide unit and the control structs that drive it.
// ----------------------------------------------------------------------------
package rvn_pkg;

  // the largest normalised magnitude lies in [2^29, 2^30)
  localparam int NORM_TOP   = 30;
  // one signed multiplier operand covers an edge or a normalised magnitude
  localparam int MUL_W      = 31;
  localparam int PROD_W     = 2 * MUL_W;
  // sum of three squares of normalised magnitudes
  localparam int SQ_W       = 62;
  localparam int ROOT_W     = SQ_W / 2;
  // divide: ((a << 15) + mag) / (2 * mag)
  localparam int FRAC_SHIFT = 15;
  localparam int NUM_W      = 46;
  localparam int DEN_W      = ROOT_W + 1;
  localparam int QUO_W      = 16;
  // partial remainder of the shared unit
  localparam int REM_W      = 34;

  // Q1.14 output
  localparam int OUT_W = 16;
  localparam logic signed [OUT_W-1:0] Q_ONE = 16'sd16384;

  typedef enum logic {
    SD_SQRT,
    SD_DIV
  } sd_op_e;

  typedef struct packed {
    logic   start;
    sd_op_e op;
  } sd_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sd_stat_t;

endpackage

// ----- sv/rvn_in_if.sv -----
// ----------------------------------------------------------------------------
// rvn_in_if: neighbour request channel
// One ring neighbour per request, with the centre vertex and a last marker.
// ----------------------------------------------------------------------------
interface rvn_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic signed [COORD_BITS-1:0] neighbor_x;
  logic signed [COORD_BITS-1:0] neighbor_y;
  logic signed [COORD_BITS-1:0] neighbor_z;
  logic                         last_neighbor;

  modport source (
    output valid, center_x, center_y, center_z,
    output neighbor_x, neighbor_y, neighbor_z, last_neighbor,
    input  ready
  );

  modport sink (
    input  valid, center_x, center_y, center_z,
    input  neighbor_x, neighbor_y, neighbor_z, last_neighbor,
    output ready
  );
endinterface

// ----- sv/rvn_out_if.sv -----
// ----------------------------------------------------------------------------
// rvn_out_if: normal result channel
// One unit normal in Q1.14 per ring, with a degenerate flag.
// ----------------------------------------------------------------------------
interface rvn_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rvn_pkg::OUT_W-1:0]   normal_x;
  logic signed [rvn_pkg::OUT_W-1:0]   normal_y;
  logic signed [rvn_pkg::OUT_W-1:0]   normal_z;
  logic                               degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );

  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

// ----- sv/ring_vertex_normal_unit.sv -----
// ----------------------------------------------------------------------------
// ring_vertex_normal_unit: vertex normal from a ring of neighbours
// Sums the cross products of consecutive edges around a vertex and scales
// the sum to a Q1.14 unit normal.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one ring neighbour per request, in ring order, with the
//   centre vertex (taken from the first request of a ring only) and a last
//   marker. out_o carries one normal per ring, on the request marked last.
//   All arithmetic runs through one registered multiplier and one iterative
//   square root / divide unit, so in_i.ready is high only while idle.
//   Each neighbour: the first of a ring and any beyond MAX_RING are only
//   accepted; every other neighbour is accepted, then runs six multiplies
//   through the shared multiplier and a drain step.
//   For the last request: its own cross term if any, the closing cross
//   term, magnitude, range shift (one bit of shift per step, at most 29
//   bits), three squares, square root (two bits a step) and three divides,
//   then the output register, which a zero sum reaches straight from magnitude.
//   The result sits in an output register; a stalled receiver holds it, and
//   the next ring may be taken meanwhile, but its result waits until the
//   previous one has been taken.
//   Reset clears the sequencer and ends any ring in progress; no reset sweep.
// ----------------------------------------------------------------------------
module ring_vertex_normal_unit #(
  parameter int COORD_BITS = 16,
  parameter int MAX_RING   = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvn_in_if.sink     in_i,
  rvn_out_if.source  out_o
);

  localparam int EdgeW = COORD_BITS + 1;
  localparam int SumW  = 2 * EdgeW + 2 + $clog2(MAX_RING);
  localparam int AbsW  = (SumW > rvn_pkg::MUL_W) ? SumW : rvn_pkg::MUL_W;
  localparam int CntW  = $clog2(MAX_RING + 1);

  localparam logic [2:0] CrossLast  = 3'd6;
  localparam logic [2:0] SquareLast = 3'd3;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CROSS  = 3'd1;
  localparam logic [2:0] S_ABS    = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_SQUARE = 3'd4;
  localparam logic [2:0] S_SQRT   = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;

  // ring state
  logic                         started_q, started_d;
  logic [CntW-1:0]              count_q, count_d;
  logic                         last_q, last_d;
  logic                         close_q, close_d;
  logic [2:0]                   step_q, step_d;
  logic [1:0]                   comp_q, comp_d;
  logic                         run_q, run_d;

  logic signed [COORD_BITS-1:0] center_q [3];
  logic signed [COORD_BITS-1:0] center_d [3];
  logic signed [EdgeW-1:0]      first_q  [3];
  logic signed [EdgeW-1:0]      first_d  [3];
  logic signed [EdgeW-1:0]      prev_q   [3];
  logic signed [EdgeW-1:0]      prev_d   [3];
  logic signed [EdgeW-1:0]      cur_q    [3];
  logic signed [EdgeW-1:0]      cur_d    [3];
  logic signed [SumW-1:0]       sum_q    [3];
  logic signed [SumW-1:0]       sum_d    [3];
  logic [AbsW-1:0]              abs_q    [3];
  logic [AbsW-1:0]              abs_d    [3];
  logic [rvn_pkg::SQ_W-1:0]     sq_q, sq_d;
  logic [rvn_pkg::ROOT_W-1:0]   mag_q, mag_d;
  logic [rvn_pkg::QUO_W-1:0]    quo_q    [3];
  logic [rvn_pkg::QUO_W-1:0]    quo_d    [3];
  logic                         deg_q, deg_d;

  // multiplier tags, registered at the issue in step with the product
  logic                         mv_q, mv_d;
  logic [1:0]                   mcomp_q, mcomp_d;
  logic                         mneg_q, mneg_d;
  logic                         msq_q, msq_d;

  // output register
  logic                              out_vld_q, out_vld_d;
  logic signed [rvn_pkg::OUT_W-1:0]  onx_q, ony_q, onz_q;
  logic                              odeg_q;
  logic                              out_load;

  // request payload as arrays
  logic signed [COORD_BITS-1:0] c_in  [3];
  logic signed [COORD_BITS-1:0] nb_in [3];
  logic signed [EdgeW-1:0]      edge_in [3];

  // shared units
  logic                                mul_en;
  logic signed [rvn_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic signed [rvn_pkg::PROD_W-1:0]   prod;
  logic signed [SumW-1:0]              prod_t;
  logic signed [SumW-1:0]              addend;
  rvn_pkg::sd_ctrl_t                   sd_ctrl;
  rvn_pkg::sd_stat_t                   sd_stat;
  logic [rvn_pkg::SQ_W-1:0]            sd_num;
  logic [rvn_pkg::DEN_W-1:0]           sd_den;
  logic [rvn_pkg::ROOT_W-1:0]          sd_res;

  // cross term selection
  logic [1:0]                   ia, ib, xcomp;
  logic                         xneg;
  logic signed [EdgeW-1:0]      opb [3];

  // magnitude and divide helpers
  logic signed [SumW-1:0]       neg_sum [3];
  logic [SumW-1:0]              mag_abs [3];
  logic                         sum_zero;
  logic                         any_hi, any_lo;
  logic [AbsW-1:0]              abs_sel;
  logic [rvn_pkg::NUM_W-1:0]    div_num;
  logic [rvn_pkg::QUO_W-1:0]    quo_pos, quo_neg;

  assign c_in[0]  = in_i.center_x;
  assign c_in[1]  = in_i.center_y;
  assign c_in[2]  = in_i.center_z;
  assign nb_in[0] = in_i.neighbor_x;
  assign nb_in[1] = in_i.neighbor_y;
  assign nb_in[2] = in_i.neighbor_z;

  // edge of the incoming neighbour; a new ring uses the incoming centre
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      edge_in[i] = EdgeW'(nb_in[i]) - EdgeW'(started_q ? center_q[i] : c_in[i]);
      opb[i]     = close_q ? first_q[i] : cur_q[i];
      neg_sum[i] = -sum_q[i];
      mag_abs[i] = sum_q[i][SumW-1] ? neg_sum[i] : sum_q[i];
    end
  end

  // multiply schedule of one cross product, prev x other
  always_comb begin
    case (step_q)
      3'd0:    begin ia = 2'd1; ib = 2'd2; xcomp = 2'd0; xneg = 1'b0; end
      3'd1:    begin ia = 2'd2; ib = 2'd1; xcomp = 2'd0; xneg = 1'b1; end
      3'd2:    begin ia = 2'd2; ib = 2'd0; xcomp = 2'd1; xneg = 1'b0; end
      3'd3:    begin ia = 2'd0; ib = 2'd2; xcomp = 2'd1; xneg = 1'b1; end
      3'd4:    begin ia = 2'd0; ib = 2'd1; xcomp = 2'd2; xneg = 1'b0; end
      3'd5:    begin ia = 2'd1; ib = 2'd0; xcomp = 2'd2; xneg = 1'b1; end
      default: begin ia = 2'd0; ib = 2'd0; xcomp = 2'd0; xneg = 1'b0; end
    endcase
  end

  // accumulator addend from the registered product
  assign prod_t = SumW'(prod);
  assign addend = mneg_q ? -prod_t : prod_t;

  // range checks of the normalisation window
  always_comb begin
    sum_zero = 1'b1;
    any_hi   = 1'b0;
    any_lo   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (sum_q[i] != '0) sum_zero = 1'b0;
      if (|abs_q[i][AbsW-1:rvn_pkg::NORM_TOP]) any_hi = 1'b1;
      if (|abs_q[i][AbsW-1:rvn_pkg::NORM_TOP-1]) any_lo = 1'b1;
    end
  end

  // divide operands: (a << 15) + mag over 2 * mag
  assign abs_sel = abs_q[comp_q];
  assign div_num = rvn_pkg::NUM_W'({abs_sel[rvn_pkg::NORM_TOP-1:0],
                                    rvn_pkg::FRAC_SHIFT'(0)})
                 + rvn_pkg::NUM_W'(mag_q);
  assign sd_num  = (state_q == S_DIV) ? rvn_pkg::SQ_W'(div_num) : sq_q;
  assign sd_den  = {mag_q, 1'b0};
  assign quo_pos = sd_res[rvn_pkg::QUO_W-1:0];
  assign quo_neg = -quo_pos;

  assign out_load = (state_q == S_EMIT) && (!out_vld_q || out_o.ready);

  // sequencer and next state of the datapath
  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    count_d   = count_q;
    last_d    = last_q;
    close_d   = close_q;
    step_d    = step_q;
    comp_d    = comp_q;
    run_d     = run_q;
    sq_d      = sq_q;
    mag_d     = mag_q;
    deg_d     = deg_q;
    for (int i = 0; i < 3; i++) begin
      center_d[i] = center_q[i];
      first_d[i]  = first_q[i];
      prev_d[i]   = prev_q[i];
      cur_d[i]    = cur_q[i];
      sum_d[i]    = sum_q[i];
      abs_d[i]    = abs_q[i];
      quo_d[i]    = quo_q[i];
    end
    mv_d    = 1'b0;
    mcomp_d = mcomp_q;
    mneg_d  = mneg_q;
    msq_d   = msq_q;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    sd_ctrl.start = 1'b0;
    sd_ctrl.op    = rvn_pkg::SD_SQRT;
    out_vld_d = (out_vld_q && !out_o.ready) || out_load;

    // accumulate the product issued last cycle
    if (mv_q) begin
      if (msq_q) begin
        sq_d = sq_q + rvn_pkg::SQ_W'($unsigned(prod));
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (mcomp_q == 2'(i)) sum_d[i] = sum_q[i] + addend;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          last_d = in_i.last_neighbor;
          step_d = '0;
          for (int i = 0; i < 3; i++) cur_d[i] = edge_in[i];
          if (!started_q) begin
            // first neighbour opens the ring
            for (int i = 0; i < 3; i++) begin
              center_d[i] = c_in[i];
              first_d[i]  = edge_in[i];
              prev_d[i]   = edge_in[i];
              sum_d[i]    = '0;
            end
            started_d = 1'b1;
            count_d   = CntW'(1);
          end
          if (started_q && (count_q < CntW'(MAX_RING))) begin
            close_d = 1'b0;
            state_d = S_CROSS;
          end else if (in_i.last_neighbor) begin
            close_d = 1'b1;
            state_d = S_CROSS;
          end
        end
      end

      S_CROSS: begin
        if (step_q != CrossLast) begin
          mul_en  = 1'b1;
          mul_a   = rvn_pkg::MUL_W'(prev_q[ia]);
          mul_b   = rvn_pkg::MUL_W'(opb[ib]);
          mv_d    = 1'b1;
          mcomp_d = xcomp;
          mneg_d  = xneg;
          msq_d   = 1'b0;
          step_d  = step_q + 1'b1;
        end else if (!close_q) begin
          for (int i = 0; i < 3; i++) prev_d[i] = cur_q[i];
          count_d = count_q + 1'b1;
          step_d  = '0;
          if (last_q) begin
            close_d = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          // closing term done: ring ends here
          started_d = 1'b0;
          count_d   = '0;
          state_d   = S_ABS;
        end
      end

      S_ABS: begin
        for (int i = 0; i < 3; i++) abs_d[i] = AbsW'(mag_abs[i]);
        if (sum_zero) begin
          deg_d = 1'b1;
          for (int i = 0; i < 3; i++) quo_d[i] = '0;
          state_d = S_EMIT;
        end else begin
          deg_d   = 1'b0;
          state_d = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // one bit a cycle, the largest magnitude into [2^29, 2^30)
        if (any_hi) begin
          for (int i = 0; i < 3; i++) abs_d[i] = abs_q[i] >> 1;
        end else if (!any_lo) begin
          for (int i = 0; i < 3; i++) abs_d[i] = abs_q[i] << 1;
        end else begin
          sq_d    = '0;
          step_d  = '0;
          state_d = S_SQUARE;
        end
      end

      S_SQUARE: begin
        if (step_q != SquareLast) begin
          mul_en = 1'b1;
          mul_a  = rvn_pkg::MUL_W'(abs_q[step_q[1:0]][rvn_pkg::NORM_TOP-1:0]);
          mul_b  = rvn_pkg::MUL_W'(abs_q[step_q[1:0]][rvn_pkg::NORM_TOP-1:0]);
          mv_d   = 1'b1;
          msq_d  = 1'b1;
          step_d = step_q + 1'b1;
        end else begin
          run_d   = 1'b0;
          state_d = S_SQRT;
        end
      end

      S_SQRT: begin
        if (!run_q) begin
          sd_ctrl.start = 1'b1;
          sd_ctrl.op    = rvn_pkg::SD_SQRT;
          run_d         = 1'b1;
        end else if (sd_stat.done) begin
          mag_d   = sd_res;
          run_d   = 1'b0;
          comp_d  = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        if (!run_q) begin
          sd_ctrl.start = 1'b1;
          sd_ctrl.op    = rvn_pkg::SD_DIV;
          run_d         = 1'b1;
        end else if (sd_stat.done) begin
          for (int i = 0; i < 3; i++) begin
            if (comp_q == 2'(i)) quo_d[i] = sum_q[i][SumW-1] ? quo_neg : quo_pos;
          end
          run_d = 1'b0;
          if (comp_q == 2'd2) begin
            state_d = S_EMIT;
          end else begin
            comp_d = comp_q + 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      count_q   <= '0;
      step_q    <= '0;
      comp_q    <= '0;
      run_q     <= 1'b0;
      mv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      count_q   <= count_d;
      step_q    <= step_d;
      comp_q    <= comp_d;
      run_q     <= run_d;
      mv_q      <= mv_d;
      out_vld_q <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    close_q <= close_d;
    sq_q    <= sq_d;
    mag_q   <= mag_d;
    deg_q   <= deg_d;
    mcomp_q <= mcomp_d;
    mneg_q  <= mneg_d;
    msq_q   <= msq_d;
    for (int i = 0; i < 3; i++) begin
      center_q[i] <= center_d[i];
      first_q[i]  <= first_d[i];
      prev_q[i]   <= prev_d[i];
      cur_q[i]    <= cur_d[i];
      sum_q[i]    <= sum_d[i];
      abs_q[i]    <= abs_d[i];
      quo_q[i]    <= quo_d[i];
    end
    if (out_load) begin
      onx_q  <= quo_q[0];
      ony_q  <= quo_q[1];
      onz_q  <= quo_q[2];
      odeg_q <= deg_q;
    end
  end

  // shared units
  rvn_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rvn_sqdiv u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sd_ctrl),
    .num_i  (sd_num),
    .den_i  (sd_den),
    .stat_o (sd_stat),
    .res_o  (sd_res)
  );

  // channel outputs
  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.normal_x   = onx_q;
  assign out_o.normal_y   = ony_q;
  assign out_o.normal_z   = onz_q;
  assign out_o.degenerate = odeg_q;

  // the shared root / divide unit is never restarted while it runs
  a_sd_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_ctrl.start |-> !sd_stat.busy)
    else $error("root/divide unit restarted while busy");

  // nothing is in flight when a new request can be taken
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!sd_stat.busy && !mv_q))
    else $error("request taken while arithmetic in flight");

  // an open ring holds a nonzero count of edges, at most MAX_RING
  a_ring_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (count_q != '0 && count_q <= CntW'(MAX_RING)))
    else $error("ring edge count out of range");

  // a unit normal stays within Q1.14 one
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !odeg_q) |->
      (onx_q <= rvn_pkg::Q_ONE && onx_q >= -rvn_pkg::Q_ONE &&
       ony_q <= rvn_pkg::Q_ONE && ony_q >= -rvn_pkg::Q_ONE &&
       onz_q <= rvn_pkg::Q_ONE && onz_q >= -rvn_pkg::Q_ONE))
    else $error("normal component beyond unit range");

  // a degenerate ring reports a zero normal
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && odeg_q) |-> (onx_q == '0 && ony_q == '0 && onz_q == '0))
    else $error("degenerate result with nonzero normal");

endmodule

// ----- sv/rvn_mul.sv -----
// ----------------------------------------------------------------------------
// rvn_mul: shared signed multiplier
// One product per cycle while en_i is high, registered, used for cross terms and squares.
// ----------------------------------------------------------------------------
module rvn_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [rvn_pkg::MUL_W-1:0]   a_i,
  input  logic signed [rvn_pkg::MUL_W-1:0]   b_i,
  output logic signed [rvn_pkg::PROD_W-1:0]  p_o
);

  logic signed [rvn_pkg::PROD_W-1:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- sv/rvn_sqdiv.sv -----
// ----------------------------------------------------------------------------
// rvn_sqdiv: iterative square root and divide unit
// One compare and subtract per cycle: two radicand bits per step for the
// square root, one numerator bit per step for the divide.
// ----------------------------------------------------------------------------
module rvn_sqdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rvn_pkg::sd_ctrl_t            ctrl_i,
  input  logic [rvn_pkg::SQ_W-1:0]     num_i,
  input  logic [rvn_pkg::DEN_W-1:0]    den_i,
  output rvn_pkg::sd_stat_t            stat_o,
  output logic [rvn_pkg::ROOT_W-1:0]   res_o
);

  localparam int CntW = $clog2(rvn_pkg::ROOT_W + 1);

  logic                         busy_q;
  logic                         done_q;
  logic [CntW-1:0]              cnt_q;
  rvn_pkg::sd_op_e              op_q;
  logic [rvn_pkg::REM_W-1:0]    rem_q;
  logic [rvn_pkg::SQ_W-1:0]     src_q;
  logic [rvn_pkg::ROOT_W-1:0]   res_q;
  logic [rvn_pkg::DEN_W-1:0]    den_q;

  logic [rvn_pkg::REM_W-1:0]    cand;
  logic [rvn_pkg::REM_W-1:0]    trial;
  logic [rvn_pkg::REM_W-1:0]    diff;
  logic                         ge;

  // one step: shift in the next bits and try the subtraction
  always_comb begin
    case (op_q)
      rvn_pkg::SD_SQRT: begin
        cand  = {rem_q[rvn_pkg::REM_W-3:0], src_q[rvn_pkg::SQ_W-1 -: 2]};
        trial = rvn_pkg::REM_W'({res_q, 2'b01});
      end
      default: begin
        cand  = {rem_q[rvn_pkg::REM_W-2:0], src_q[rvn_pkg::SQ_W-1]};
        trial = rvn_pkg::REM_W'(den_q);
      end
    endcase
    ge   = (cand >= trial);
    diff = cand - trial;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rvn_pkg::SD_SQRT;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        cnt_q  <= (ctrl_i.op == rvn_pkg::SD_SQRT) ? CntW'(rvn_pkg::ROOT_W)
                                                 : CntW'(rvn_pkg::QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      res_q <= '0;
      den_q <= den_i;
      if (ctrl_i.op == rvn_pkg::SD_SQRT) begin
        rem_q <= '0;
        src_q <= num_i;
      end else begin
        // high part is already below the divisor
        rem_q <= rvn_pkg::REM_W'(num_i[rvn_pkg::NUM_W-1:rvn_pkg::QUO_W]);
        src_q <= {num_i[rvn_pkg::QUO_W-1:0], (rvn_pkg::SQ_W - rvn_pkg::QUO_W)'(0)};
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff : cand;
      res_q <= {res_q[rvn_pkg::ROOT_W-2:0], ge};
      src_q <= (op_q == rvn_pkg::SD_SQRT) ? (src_q << 2) : (src_q << 1);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule
